>>> design/fld_pkg.sv
// Shared types and constants for the field line doubler.
package fld_pkg;

	// Default bounds of the line buffer and row counter
	localparam int DEF_MAX_LINE_BYTES = 8192;
	localparam int DEF_MAX_FIELD_ROWS = 1024;

	// Fixed field widths
	localparam int SAMPLE_W = 8;
	localparam int ROW_W    = 11;
	localparam int COL_W    = 13;
	localparam int LINE_W   = 14;
	localparam int ROWS_W   = 11;
	localparam int INDEX_W  = 4;

	// Register indexes
	localparam logic [INDEX_W-1:0] REG_LINE_BYTES = 4'd0;
	localparam logic [INDEX_W-1:0] REG_FIELD_ROWS = 4'd1;

	// Register reset values
	localparam logic [LINE_W-1:0] LINE_BYTES_RESET = 14'd7680;
	localparam logic [ROWS_W-1:0] FIELD_ROWS_RESET = 11'd540;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// One classified item waiting for output: both results of the pair
	typedef struct packed {
		logic [ROW_W-1:0]    row_base;
		logic [COL_W-1:0]    col;
		logic [SAMPLE_W-1:0] old;
		logic [SAMPLE_W-1:0] interp;
		logic                done;
	} fld_entry_t;

	// Front to queue
	typedef struct packed {
		logic       push;
		fld_entry_t entry;
	} fld_push_t;

	// Queue to back
	typedef struct packed {
		logic       avail;
		fld_entry_t entry;
	} fld_head_t;

endpackage

>>> design/fld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the contents from before a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/fld_front.sv
// Front end: registers, position counters, line buffer and item classification.
module fld_front import fld_pkg::*; #(
	parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
	parameter int MAX_FIELD_ROWS = DEF_MAX_FIELD_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [LINE_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                full,
	output fld_push_t           push
);

	localparam int CW = $clog2(MAX_LINE_BYTES);
	localparam int RW = (MAX_FIELD_ROWS > 2) ? $clog2(MAX_FIELD_ROWS) : 1;
	localparam logic [CW-1:0] COL_TOP = CW'(MAX_LINE_BYTES - 1);
	localparam logic [RW-1:0] ROW_TOP = RW'(MAX_FIELD_ROWS - 1);

	logic [LINE_W-1:0] line_bytes_q;
	logic [ROWS_W-1:0] field_rows_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;

	logic [CW-1:0]     last_col;
	logic [RW-1:0]     last_row;
	logic              col_end;
	logic              row_end;
	logic              accept;
	logic              advance;
	logic [31:0]       base_w;
	logic [31:0]       col_w;

	logic                s1_valid_q;
	logic                s1_has_s1;
	logic                s1_done_s1;
	logic [ROW_W-1:0]    s1_row_s1;
	logic [COL_W-1:0]    s1_col_s1;
	logic [SAMPLE_W-1:0] s1_sample_s1;
	logic [SAMPLE_W-1:0] old;

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= LINE_BYTES_RESET;
			field_rows_q <= FIELD_ROWS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINE_BYTES: line_bytes_q <= cfg_data;
				REG_FIELD_ROWS: field_rows_q <= cfg_data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the bounds and express them as last column and last row
	always_comb begin
		if (line_bytes_q == '0) begin
			last_col = '0;
		end else if (32'(line_bytes_q) > 32'(MAX_LINE_BYTES)) begin
			last_col = COL_TOP;
		end else begin
			last_col = CW'(line_bytes_q - LINE_W'(1));
		end
		if (field_rows_q < ROWS_W'(2)) begin
			last_row = RW'(1);
		end else if (32'(field_rows_q) > 32'(MAX_FIELD_ROWS)) begin
			last_row = ROW_TOP;
		end else begin
			last_row = RW'(field_rows_q - ROWS_W'(1));
		end
	end

	assign col_end = (col_q >= last_col);
	assign row_end = (row_q >= last_row);

	// Stage one moves on when empty, when it carries nothing, or when the queue has room
	assign advance  = !s1_valid_q || !s1_has_s1 || !full;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	// Advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line buffer: read the previous row's byte and replace it in the same cycle
	fld_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_LINE_BYTES)
	) u_line (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(sample),
		.re   (accept),
		.raddr(col_q),
		.rdata(old)
	);

	// Destination row and column in the doubled frame
	assign base_w = (32'(row_q) - 32'd1) << 1;
	assign col_w  = 32'(col_q);

	// Stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_has_s1    <= (row_q != '0);
			s1_done_s1   <= row_end && col_end;
			s1_row_s1    <= base_w[ROW_W-1:0];
			s1_col_s1    <= col_w[COL_W-1:0];
			s1_sample_s1 <= sample;
		end
	end

	// Push items of rows past the first, with the buffered byte attached
	always_comb begin
		push.push           = s1_valid_q && s1_has_s1 && !full;
		push.entry.row_base = s1_row_s1;
		push.entry.col      = s1_col_s1;
		push.entry.old      = old;
		push.entry.interp   = (old >> 1) + (s1_sample_s1 >> 1);
		push.entry.done     = s1_done_s1;
	end

endmodule

>>> design/fld_queue.sv
// Short queue of classified items between front and back.
module fld_queue import fld_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fld_push_t push,
	output logic      full,
	input  logic      pop,
	output fld_head_t head
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	fld_entry_t    slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   count_q;
	logic          do_pop;

	assign full   = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign do_pop = pop && (count_q != '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push.push && !do_pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (!push.push && do_pop) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push.push) begin
			slot_q[wr_q] <= push.entry;
		end
	end

	assign head.avail = (count_q != '0);
	assign head.entry = slot_q[rd_q];

endmodule

>>> design/fld_back.sv
// Back end: expands each queued item into its copy and interpolated results.
module fld_back import fld_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  fld_head_t           head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ROW_W-1:0]    out_row,
	output logic [COL_W-1:0]    out_col,
	output logic [SAMPLE_W-1:0] value,
	output logic                last,
	output logic                frame_done
);

	logic                out_valid_q;
	logic                phase_q;
	logic                load;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [SAMPLE_W-1:0] value_q;
	logic                last_q;
	logic                done_q;

	// Output register takes a new result when empty or being taken
	assign load = !out_valid_q || out_ready;
	assign pop  = load && head.avail && phase_q;

	// Output valid and pair phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= head.avail;
			if (head.avail) begin
				phase_q <= !phase_q;
			end
		end
	end

	// Output payload: copy first, interpolated second
	always_ff @(posedge clk) begin
		if (load && head.avail) begin
			row_q   <= {head.entry.row_base[ROW_W-1:1], phase_q};
			col_q   <= head.entry.col;
			value_q <= phase_q ? head.entry.interp : head.entry.old;
			last_q  <= phase_q;
			done_q  <= phase_q && head.entry.done;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = row_q;
	assign out_col    = col_q;
	assign value      = value_q;
	assign last       = last_q;
	assign frame_done = done_q;

endmodule

>>> design/field_line_doubler_core.sv
// Top level of the field line doubler: front end, queue and back end.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in_valid / in_ready   | sample
//   out     | out_valid / out_ready | out_row, out_col, value, last, frame_done
//
// Bytes are accepted one per cycle while the four-entry queue has room; each byte of a
// later row gives two results, which the output register sends one per cycle while
// out_ready is high, so such bytes go at half that rate (one per cycle on a field's first row).
// A first result passes the stage-one register, a queue slot and the output register.
// Reset clears the counters, queue and output valid; the line buffer is not cleared.
// Either side may stall at any time; cfg_ready is always high.
module field_line_doubler_core import fld_pkg::*; #(
	parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
	parameter int MAX_FIELD_ROWS = DEF_MAX_FIELD_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [LINE_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ROW_W-1:0]    out_row,
	output logic [COL_W-1:0]    out_col,
	output logic [SAMPLE_W-1:0] value,
	output logic                last,
	output logic                frame_done
);

	fld_push_t push;
	fld_head_t head;
	logic      full;
	logic      pop;

	assign cfg_ready = 1'b1;

	// Classify and look up the previous row
	fld_front #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES),
		.MAX_FIELD_ROWS(MAX_FIELD_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.full     (full),
		.push     (push)
	);

	// Hold items between the two sides
	fld_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.pop   (pop),
		.head  (head)
	);

	// Emit result pairs
	fld_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.value     (value),
		.last      (last),
		.frame_done(frame_done)
	);

endmodule

>>> bench/field_line_doubler_checker.sv
// Checker for the field line doubler: predicts the doubled-frame writes and compares them.
module field_line_doubler_checker import fld_pkg::*; #(
	parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
	parameter int MAX_FIELD_ROWS = DEF_MAX_FIELD_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [LINE_W-1:0]   cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [ROW_W-1:0]    out_row,
	input  logic [COL_W-1:0]    out_col,
	input  logic [SAMPLE_W-1:0] value,
	input  logic                last,
	input  logic                frame_done,
	output int                  fail_count,
	output int                  pending_count
);

	localparam int REPORT_LIMIT = 10;

	// One byte write into the doubled frame
	typedef struct packed {
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [SAMPLE_W-1:0] value;
		logic                last;
		logic                done;
	} frame_write_t;

	frame_write_t        frame_writes_q[$];
	logic [SAMPLE_W-1:0] line_mem [MAX_LINE_BYTES];
	logic [LINE_W-1:0]   line_bytes;
	logic [ROWS_W-1:0]   field_rows;
	int                  col_pos;
	int                  row_pos;
	int                  mismatches = 0;

	assign fail_count = mismatches;

	// Work out the pair of writes one field byte past the first row causes, then advance the raster position
	task automatic double_sample(input logic [SAMPLE_W-1:0] s);
		int           lb;
		int           rows;
		logic [SAMPLE_W-1:0] old;
		frame_write_t w;
		lb = (line_bytes == 0) ? 1 :
			(line_bytes > MAX_LINE_BYTES) ? MAX_LINE_BYTES : int'(line_bytes);
		rows = (field_rows < 2) ? 2 :
			(field_rows > MAX_FIELD_ROWS) ? MAX_FIELD_ROWS : int'(field_rows);
		if (row_pos >= 1) begin
			old = line_mem[col_pos];
			// copy of the buffered byte on the even row
			w.row   = ROW_W'(2 * (row_pos - 1));
			w.col   = COL_W'(col_pos);
			w.value = old;
			w.last  = 1'b0;
			w.done  = 1'b0;
			frame_writes_q.push_back(w);
			// average of both rows on the odd row
			w.row   = ROW_W'(2 * (row_pos - 1) + 1);
			w.value = (old >> 1) + (s >> 1);
			w.last  = 1'b1;
			w.done  = (row_pos + 1 >= rows) && (col_pos + 1 >= lb);
			frame_writes_q.push_back(w);
		end
		line_mem[col_pos] = s;
		// wrap column, then row, at the current bounds
		if (col_pos + 1 >= lb) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	// Compare the write on the result channel with the oldest prediction
	task automatic check_write();
		frame_write_t got;
		frame_write_t want;
		got = '{row: out_row, col: out_col, value: value, last: last, done: frame_done};
		if (frame_writes_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("unexpected result: row %0d col %0d value %0d last %0b done %0b",
					got.row, got.col, got.value, got.last, got.done);
		end else begin
			want = frame_writes_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"mismatch: expected row %0d col %0d value %0d last %0b",
						" done %0b, got row %0d col %0d value %0d last %0b done %0b"},
						want.row, want.col, want.value, want.last, want.done,
						got.row, got.col, got.value, got.last, got.done);
			end
		end
	endtask

	// Watch all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_writes_q.delete();
			col_pos       = 0;
			row_pos       = 0;
			line_bytes    = LINE_BYTES_RESET;
			field_rows    = FIELD_ROWS_RESET;
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready)
				check_write();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LINE_BYTES: line_bytes = cfg_data;
					REG_FIELD_ROWS: field_rows = cfg_data[ROWS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				double_sample(sample);
			pending_count <= frame_writes_q.size();
		end
	end

endmodule

>>> bench/tb_field_line_doubler_core.sv
// Testbench top for the field line doubler core: stimulus, ready pressure and verdict.
module tb_field_line_doubler_core;
	import fld_pkg::*;

	localparam int     HALF_PERIOD      = 6;
	localparam int     RESET_CYCLES     = 6;
	localparam int     DRAIN_CYCLES     = 16;
	localparam int     SINK_HOLD_CYCLES = 200;
	localparam int     RANDOM_ITEMS     = 900;
	localparam int     CALM_AFTER       = 720;
	localparam longint TIMEOUT_UNITS    = 40_000_000;
	localparam logic [INDEX_W-1:0] REG_SPARE = 4'hF;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [INDEX_W-1:0]  cfg_index  = '0;
	logic [LINE_W-1:0]   cfg_data   = '0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample     = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [ROW_W-1:0]    out_row;
	logic [COL_W-1:0]    out_col;
	logic [SAMPLE_W-1:0] value;
	logic                last;
	logic                frame_done;

	logic sink_hold     = 1'b0;
	bit   calm          = 1'b0;
	int   src_idle_pct  = 0;
	int   sink_idle_pct = 0;
	int   fail_count;
	int   pending_count;

	field_line_doubler_core dut (.*);

	field_line_doubler_checker chk (.*);

	always #HALF_PERIOD clk = ~clk;

	// Bound the run
	initial begin
		#(TIMEOUT_UNITS);
		$display("** field_line_doubler_core: FAILED **");
		$finish;
	end

	// Bytes in one whole field for raw register values
	function automatic int field_len(input int lb_raw, input int rows_raw);
		int lb;
		int rows;
		lb = (lb_raw < 1) ? 1 : (lb_raw > DEF_MAX_LINE_BYTES) ? DEF_MAX_LINE_BYTES : lb_raw;
		rows = (rows_raw < 2) ? 2 :
			(rows_raw > DEF_MAX_FIELD_ROWS) ? DEF_MAX_FIELD_ROWS : rows_raw;
		return lb * rows;
	endfunction

	// Random field byte, leaning on the extremes
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// Offer one byte, with an optional idle burst first, and hold it until taken
	task automatic push_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_bytes(input int count);
		repeat (count) push_sample(pick_sample());
	endtask

	// Drop valid and let every predicted write come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [LINE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drive result ready: random hold-offs plus one long stall on request
	initial begin : sink_ready
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				out_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
				sink_hold <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
				gap = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [SAMPLE_W-1:0] first_field [9];
		logic [SAMPLE_W-1:0] tiny_field [4];
		int n;
		int sent;
		int lb_raw;
		int rows_raw;
		first_field = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd1, 8'd255, 8'd254, 8'd128};
		tiny_field  = '{8'd255, 8'd255, 8'd1, 8'd0};

		// Hold reset, then release on a clock edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: 3x3 field through all byte extremes, spare index ignored
		set_idling(10, 10);
		write_reg(REG_SPARE, 14'h3FFF);
		write_reg(REG_LINE_BYTES, 14'd3);
		write_reg(REG_FIELD_ROWS, 14'd3);
		foreach (first_field[i]) push_sample(first_field[i]);

		// Directed: line length zero and row count one act as 1 and 2
		wait_idle();
		write_reg(REG_LINE_BYTES, 14'd0);
		write_reg(REG_FIELD_ROWS, 14'd1);
		foreach (tiny_field[i]) push_sample(tiny_field[i]);

		// Line length above the maximum: the first row runs on without wrapping
		wait_idle();
		set_idling(3, 3);
		write_reg(REG_LINE_BYTES, 14'h3FFF);
		write_reg(REG_FIELD_ROWS, 14'd2);
		send_bytes(40);

		// Row count above the maximum, data bits beyond the register width,
		// one byte per row so each byte starts a new row
		wait_idle();
		write_reg(REG_LINE_BYTES, 14'd0);
		write_reg(REG_FIELD_ROWS, 14'h3FFF);
		send_bytes(24);

		// Widest legal line, then shrink it mid-row so the column wraps early
		wait_idle();
		set_idling(8, 8);
		write_reg(REG_LINE_BYTES, 14'd8192);
		write_reg(REG_FIELD_ROWS, 14'd3);
		send_bytes(30);
		wait_idle();
		write_reg(REG_LINE_BYTES, 14'd4);
		send_bytes(9);

		// Shrink the row count mid-field below the current row
		wait_idle();
		write_reg(REG_FIELD_ROWS, 14'd6);
		send_bytes(14);
		wait_idle();
		write_reg(REG_FIELD_ROWS, 14'd2);
		send_bytes(2);

		// Long receiver stall while bytes keep coming
		wait_idle();
		write_reg(REG_LINE_BYTES, 14'd3);
		write_reg(REG_FIELD_ROWS, 14'd4);
		set_idling(0, 0);
		sink_hold <= 1'b1;
		send_bytes(2 * field_len(3, 4));

		// Random whole fields with random geometry and idling
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: lb_raw = 0;
				1, 2: lb_raw = $urandom_range(9, 24);
				default: lb_raw = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 9))
				0: rows_raw = $urandom_range(0, 1);
				1: rows_raw = $urandom_range(7, 12);
				default: rows_raw = $urandom_range(2, 6);
			endcase
			if (sent >= CALM_AFTER)
				calm = 1'b1;
			wait_idle();
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_SPARE, LINE_W'($urandom));
			write_reg(REG_LINE_BYTES, LINE_W'(lb_raw));
			write_reg(REG_FIELD_ROWS, LINE_W'(rows_raw));
			case ($urandom_range(0, 3))
				0: set_idling(0, 0);
				1: set_idling(3, 3);
				2: set_idling(15, 4);
				default: set_idling(4, 20);
			endcase
			n = $urandom_range(1, 2) * field_len(lb_raw, rows_raw);
			send_bytes(n);
			sent += n;
		end

		// Drain and report
		wait_idle();
		if (fail_count == 0 && pending_count == 0) begin
			$display("** field_line_doubler_core: PASSED **");
		end else begin
			$display("** field_line_doubler_core: FAILED **");
		end
		$finish;
	end

endmodule
